>>> sv/lafs_pkg.sv
// ----------------------------------------------------------------------------
// lafs_pkg
// Shared types and constants for the line assembler / field splitter.
// ----------------------------------------------------------------------------
package lafs_pkg;

	// special bytes
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_BAR = 8'h7C;
	localparam logic [7:0] CH_NUL = 8'h00;

	// status classes
	typedef enum logic [2:0] {
		CLS_OK      = 3'd0,
		CLS_ERR     = 3'd1,
		CLS_INFO    = 3'd2,
		CLS_EVENT   = 3'd3,
		CLS_UNKNOWN = 3'd4
	} cls_t;

	// status words, indexed by class, padded with zeros
	localparam int         NUM_WORDS = 4;
	localparam int         WORD_MAX  = 5;
	localparam logic [7:0] WORD_CHARS [NUM_WORDS][WORD_MAX] = '{
		'{8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00},  // OK
		'{8'h45, 8'h52, 8'h52, 8'h00, 8'h00},  // ERR
		'{8'h49, 8'h4E, 8'h46, 8'h4F, 8'h00},  // INFO
		'{8'h45, 8'h56, 8'h45, 8'h4E, 8'h54}   // EVENT
	};
	localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{3'd2, 3'd3, 3'd4, 3'd5};

	// last field number; bars past it stay in the data field
	localparam logic [1:0] FIELD_DATA = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic store;        // write the input byte into the line store
		logic overflow;     // overlong line: enter discard, bump counter
		logic clear_fill;   // line feed: empty the store
		logic clr_discard;  // line feed while discarding
		logic start;        // latch length and class, reset emit index
		logic read;         // read the store at the emit index
		logic advance;      // output word taken: step index and field
	} lafs_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_cr;
		logic is_lf;
		logic discard;
		logic full;
		logic line_nz;      // emit length is nonzero
		logic last_byte;    // current word is the final one of the line
	} lafs_stat_t;

endpackage

>>> sv/lafs_ctrl.sv
// ----------------------------------------------------------------------------
// lafs_ctrl
// Controller: accepts bytes while idle, then walks the stored line out.
// ----------------------------------------------------------------------------
module lafs_ctrl
	import lafs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  lafs_stat_t stat,
	output lafs_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_SHOW = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SHOW);
	assign acc       = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && !stat.is_cr) begin
					if (stat.is_lf) begin
						cmd.clear_fill = 1'b1;
						if (stat.discard) begin
							cmd.clr_discard = 1'b1;
						end else if (stat.line_nz) begin
							cmd.start = 1'b1;
							state_d   = ST_READ;
						end
					end else if (!stat.discard) begin
						if (stat.full) cmd.overflow = 1'b1;
						else           cmd.store    = 1'b1;
					end
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_ready) begin
					cmd.advance = 1'b1;
					state_d     = stat.last_byte ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

>>> sv/lafs_dp.sv
// ----------------------------------------------------------------------------
// lafs_dp
// Datapath: line store, fill count, per-line tracking of the first zero and
// the status word, overflow counter and emit registers.
// ----------------------------------------------------------------------------
module lafs_dp
	import lafs_pkg::*;
#(
	parameter int LINE_CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  in_byte,
	input  lafs_cmd_t   cmd,
	output lafs_stat_t  stat,
	output logic [7:0]  line_byte,
	output logic [1:0]  field_number,
	output logic        is_separator,
	output logic        last,
	output logic [2:0]  status_class,
	output logic        is_terminal,
	output logic [15:0] overflow_total
);

	localparam int DEPTH = LINE_CAPACITY - 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic [CW-1:0] fill_q;
	logic          discard_q;
	logic [15:0]   ovf_q;

	// per-line tracking
	logic          zero_seen_q, zero_seen_d;
	logic [CW-1:0] zero_pos_q, zero_pos_d;
	logic          stat_open_q, stat_open_d;
	logic [2:0]    slen_q, slen_d;
	logic [NUM_WORDS-1:0] match_q, match_d;

	// emit registers
	logic [CW-1:0] len_q;
	logic [CW-1:0] idx_q;
	logic [1:0]    field_q;
	cls_t          cls_q;

	logic [CW-1:0] emit_len;
	cls_t          cls_now;

	// next tracking values for a stored byte; position zero starts fresh
	always_comb begin
		logic zs;
		logic so;
		zs          = (fill_q == '0) ? 1'b0 : zero_seen_q;
		so          = (fill_q == '0) ? 1'b1 : stat_open_q;
		zero_seen_d = zs;
		zero_pos_d  = zero_pos_q;
		stat_open_d = so;
		slen_d      = (fill_q == '0) ? 3'd0 : slen_q;
		match_d     = (fill_q == '0) ? '1 : match_q;
		if (!zs && in_byte == CH_NUL) begin
			zero_seen_d = 1'b1;
			zero_pos_d  = fill_q;
		end
		if (so) begin
			if (in_byte == CH_BAR || in_byte == CH_NUL) begin
				stat_open_d = 1'b0;
			end else begin
				for (int w = 0; w < NUM_WORDS; w++) begin
					if (slen_d >= WORD_LEN[w]) match_d[w] = 1'b0;
					else if (in_byte != WORD_CHARS[w][slen_d]) match_d[w] = 1'b0;
				end
				if (slen_d != 3'd7) slen_d = slen_d + 3'd1;
			end
		end
	end

	// class of the status field of the line held now
	always_comb begin
		cls_now = CLS_UNKNOWN;
		for (int w = NUM_WORDS - 1; w >= 0; w--) begin
			if (match_q[w] && slen_q == WORD_LEN[w]) cls_now = cls_t'(3'(w));
		end
	end

	assign emit_len = (fill_q == '0) ? '0 : (zero_seen_q ? zero_pos_q : fill_q);

	// status to the controller
	assign stat.is_cr     = (in_byte == CH_CR);
	assign stat.is_lf     = (in_byte == CH_LF);
	assign stat.discard   = discard_q;
	assign stat.full      = (fill_q == FULL_CNT);
	assign stat.line_nz   = (emit_len != '0);
	assign stat.last_byte = (idx_q + CW'(1) == len_q);

	// line store
	always_ff @(posedge clk) begin
		if (cmd.store) mem[fill_q[AW-1:0]] <= in_byte;
		if (cmd.read)  rdata_q <= mem[idx_q[AW-1:0]];
	end

	// tracking registers, written with each stored byte
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			zero_seen_q <= zero_seen_d;
			zero_pos_q  <= zero_pos_d;
			stat_open_q <= stat_open_d;
			slen_q      <= slen_d;
			match_q     <= match_d;
		end
	end

	// fill, discard and overflow count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			discard_q <= 1'b0;
			ovf_q     <= '0;
		end else begin
			if (cmd.store) fill_q <= fill_q + CW'(1);
			if (cmd.clear_fill || cmd.overflow) fill_q <= '0;
			if (cmd.overflow) begin
				discard_q <= 1'b1;
				if (ovf_q != 16'hFFFF) ovf_q <= ovf_q + 16'd1;
			end
			if (cmd.clr_discard) discard_q <= 1'b0;
		end
	end

	// emit index and field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			idx_q   <= '0;
			field_q <= '0;
			cls_q   <= CLS_UNKNOWN;
		end else if (cmd.start) begin
			len_q   <= emit_len;
			idx_q   <= '0;
			field_q <= '0;
			cls_q   <= cls_now;
		end else if (cmd.advance) begin
			idx_q <= idx_q + CW'(1);
			if (is_separator) field_q <= field_q + 2'd1;
		end
	end

	// output word
	assign line_byte      = rdata_q;
	assign field_number   = field_q;
	assign is_separator   = (rdata_q == CH_BAR) && (field_q != FIELD_DATA);
	assign last           = stat.last_byte;
	assign status_class   = last ? cls_q : 3'd0;
	assign is_terminal    = last && (cls_q == CLS_OK || cls_q == CLS_ERR);
	assign overflow_total = ovf_q;

endmodule

>>> sv/line_assembler_field_splitter.sv
// ----------------------------------------------------------------------------
// line_assembler_field_splitter
// Assembles received bytes into lines and emits each finished line byte by
// byte, tagged with its field number, separators and the status class.
// ----------------------------------------------------------------------------
// Emission: after a line feed that ends a kept line, each word is read from
//   the line store into the output register, then held until it is taken.
// Throughput: one byte per cycle while assembling.
// No input is taken while a line is being emitted.
// Reset: asynchronous, clears fill, discard flag, overflow count and the
//   controller; the line store itself is not cleared.
module line_assembler_field_splitter
	import lafs_pkg::*;
#(
	parameter int LINE_CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] line_byte, [23:8] overflow_total
	output logic        m_tlast,
	output logic [6:0]  m_tuser    // [1:0] field_number, [2] is_separator,
	                               // [5:3] status_class, [6] is_terminal
);

	lafs_cmd_t   cmd;
	lafs_stat_t  stat;
	logic [7:0]  line_byte;
	logic [1:0]  field_number;
	logic        is_separator;
	logic        last;
	logic [2:0]  status_class;
	logic        is_terminal;
	logic [15:0] overflow_total;

	lafs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lafs_dp #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_byte        (s_tdata),
		.cmd            (cmd),
		.stat           (stat),
		.line_byte      (line_byte),
		.field_number   (field_number),
		.is_separator   (is_separator),
		.last           (last),
		.status_class   (status_class),
		.is_terminal    (is_terminal),
		.overflow_total (overflow_total)
	);

	assign m_tdata = {overflow_total, line_byte};
	assign m_tlast = last;
	assign m_tuser = {is_terminal, status_class, is_separator, field_number};

	// no byte is taken while a word is shown
	a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted during line emission");

	// class and terminal flag are zero except on the final word
	a_class_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[6:3] == 4'd0)
		else $error("status class set on a non-final word");

	// overflow count only moves on an accepted byte
	a_ovf_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(m_tdata[23:8]))
		else $error("overflow count changed without input");

	// separators are bars
	a_sep_is_bar: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata[7:0] == CH_BAR)
		else $error("separator flag on a non-bar byte");

endmodule
